// ----- rtl/fpsc_pkg.sv -----
// Shared types, widths and constants for the fan PID speed controller.
// No dependencies; every RTL file of the block uses this package.
`default_nettype none

package fpsc_pkg;

   // Field widths
   localparam int TGT_W  = 12;   // target speed, RPM
   localparam int SPD_W  = 14;   // measured speed, RPM
   localparam int ERR_W  = 15;   // speed error, signed
   localparam int DUTY_W = 14;   // duty, 0.01 % steps
   localparam int PWM_W  = 22;   // PWM high time, clocks
   localparam int GAIN_W = 16;   // Q4.12 gains
   localparam int ZONE_W = 16;   // derivative dead zone
   localparam int RATE_W = 8;    // updates per second
   localparam int CPS_W  = 8;    // clocks per duty step
   localparam int CSR_W  = 16;   // widest register
   localparam int CSR_IDX_W = 3;

   // Speed change magnitude: |diff| * update_rate
   localparam int CHG_W = SPD_W + RATE_W;

   // Gain normalization, Q16. gn = target * 0.002225 = target * 89 / 40000,
   // so gn_q16 = target * 89 * 2^16 / 40000 = target * 89 * 2^10 / 625.
   localparam int GN_W      = 20;
   localparam int GN_NUM    = 89;
   localparam int GN_NUM_W  = 7;
   localparam int GN_SHIFT  = 10;
   localparam int GN_DEN    = 625;
   localparam int GN_KNEE   = 800;
   localparam int GN_LOW    = 116654;   // floor(1.78 * 2^16)
   localparam int DIV_W     = TGT_W + GN_NUM_W + GN_SHIFT;
   localparam int REM_W     = $clog2(GN_DEN);

   // Shared shift-add multiplier
   localparam int MUL_AW  = GAIN_W + GN_W;   // gain * gn
   localparam int MUL_BW  = CHG_W;           // widest multiplier operand
   localparam int PROD_W  = MUL_AW + MUL_BW;
   localparam int Q_SHIFT = 28;              // Q4.12 * Q16
   localparam int TERM_W  = PROD_W - Q_SHIFT;
   localparam int TERM_SW = TERM_W + 1;      // signed term
   localparam int SUM_W   = TERM_SW + 3;     // integral + three terms
   localparam int INT_W   = 15;              // integral accumulator

   localparam int DUTY_FULL_SCALE_DEF = 10000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEADZONE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CEILING  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CPS      = 3'd7;

   // Register reset values
   localparam logic [GAIN_W-1:0] KP_RST       = 16'd20480;
   localparam logic [GAIN_W-1:0] KI_RST       = 16'd1638;
   localparam logic [GAIN_W-1:0] KD_RST       = 16'd819;
   localparam logic [ZONE_W-1:0] DEADZONE_RST = 16'd100;
   localparam logic [RATE_W-1:0] RATE_RST     = 8'd10;
   localparam logic [DUTY_W-1:0] FLOOR_RST    = 14'd100;
   localparam logic [DUTY_W-1:0] CEILING_RST  = 14'd10000;
   localparam logic [CPS_W-1:0]  CPS_RST      = 8'd16;

   // PID term being worked on
   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCHED,
      ST_RATE,
      ST_GAIN,
      ST_MAG,
      ST_INT,
      ST_DUTY,
      ST_PWM,
      ST_HOLD
   } state_type;

   // When the two cross, a value above the ceiling gets the ceiling and any other the floor.
   function automatic logic [DUTY_W-1:0] clamp_duty(
      input logic signed [SUM_W-1:0] v,
      input logic [DUTY_W-1:0]       ceil_v,
      input logic [DUTY_W-1:0]       floor_v
   );
      logic signed [SUM_W-1:0] c;
      logic signed [SUM_W-1:0] f;
      logic [DUTY_W-1:0]       r;
      c = signed'(SUM_W'(ceil_v));
      f = signed'(SUM_W'(floor_v));
      if (v > c) begin
         r = ceil_v;
      end else if (v < f) begin
         r = floor_v;
      end else begin
         r = v[DUTY_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/fpsc_mul.sv -----
// Shared shift-add multiplier, one multiplier bit per cycle.
// Depends on fpsc_pkg for default operand widths.
`default_nettype none

module fpsc_mul #(
   parameter int AW = fpsc_pkg::MUL_AW,
   parameter int BW = fpsc_pkg::MUL_BW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic                  done,
   output logic [AW+BW-1:0]      product
);
   localparam int CntW = $clog2(BW);

   logic [AW-1:0]   a_ff, a_in;
   logic [AW-1:0]   hi_ff, hi_in;
   logic [BW-1:0]   lo_ff, lo_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [AW:0]     sum;

   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      if (start) begin
         a_in   = a;
         hi_in  = '0;
         lo_in  = b;
         cnt_in = CntW'(BW - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         // add, then shift the partial product right by one
         hi_in  = sum[AW:1];
         lo_in  = {sum[0], lo_ff[BW-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ----- rtl/fpsc_gsched.sv -----
// Gain schedule: gn in Q16 from the target speed, by a bit-serial restoring
// division by a constant, or a fixed gn at or below the knee. Depends on fpsc_pkg.
`default_nettype none

module fpsc_gsched (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [fpsc_pkg::TGT_W-1:0] target,
   output logic                            done,
   output logic [fpsc_pkg::GN_W-1:0]       gn
);
   import fpsc_pkg::*;

   localparam int CntW = $clog2(DIV_W);

   logic [DIV_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [GN_W-1:0]  quo_ff, quo_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             low_ff, low_in;
   logic [DIV_W-1:0] scaled;
   logic [REM_W:0]   trial;
   logic             fits;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      low_in  = low_ff;
      done_in = 1'b0;
      scaled  = DIV_W'(target) * DIV_W'(GN_NUM);
      trial   = {rem_ff, num_ff[DIV_W-1]};
      fits    = (trial >= (REM_W + 1)'(GN_DEN));
      if (start) begin
         num_in = scaled << GN_SHIFT;
         rem_in = '0;
         quo_in = '0;
         cnt_in = CntW'(DIV_W - 1);
         run_in = 1'b1;
         low_in = (target <= TGT_W'(GN_KNEE));
      end else if (run_ff) begin
         // one quotient bit per cycle
         rem_in = fits ? REM_W'(trial - (REM_W + 1)'(GN_DEN)) : REM_W'(trial);
         quo_in = {quo_ff[GN_W-2:0], fits};
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      low_ff <= low_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign gn   = low_ff ? GN_W'(GN_LOW) : quo_ff;

endmodule

`default_nettype wire

// ----- rtl/fan_pid_speed_controller_unit.sv -----
// Fan PID speed controller, top level: registers, sequencer and datapath.
// Depends on fpsc_pkg, fpsc_gsched and fpsc_mul.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_target_speed, req_measured_speed
//   rsp      out  rsp_valid / rsp_stall  rsp_duty, rsp_pwm_high_cycles, rsp_speed_error
//   csr      in   csr_write              csr_index, csr_data
//
// An update runs from one request transfer to the next through the serial divide of the
// gain schedule, eight passes of the shared shift-add multiplier (speed change, gain * gn
// and term size for P, I and D, PWM time), the integral clamp, the duty clamp, the result
// load and idle.
// Reset (synchronous) restores register defaults, integral half full scale, last speed 0.
// req_stall is high from transfer until the result loads; a loaded result waits under
// rsp_stall while the next update runs, and that update then holds in HOLD.
`default_nettype none

module fan_pid_speed_controller_unit #(
   parameter int DUTY_FULL_SCALE = fpsc_pkg::DUTY_FULL_SCALE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [fpsc_pkg::TGT_W-1:0]        req_target_speed,
   input  wire logic [fpsc_pkg::SPD_W-1:0]        req_measured_speed,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [fpsc_pkg::DUTY_W-1:0]            rsp_duty,
   output logic [fpsc_pkg::PWM_W-1:0]             rsp_pwm_high_cycles,
   output logic signed [fpsc_pkg::ERR_W-1:0]      rsp_speed_error,
   // register write port
   input  wire logic                              csr_write,
   input  wire logic [fpsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fpsc_pkg::CSR_W-1:0]        csr_data
);
   import fpsc_pkg::*;

   localparam logic [INT_W-1:0] IntReset = INT_W'(DUTY_FULL_SCALE / 2);

   // configuration registers
   logic [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [ZONE_W-1:0] zone_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [DUTY_W-1:0] floor_ff, ceil_ff;
   logic [CPS_W-1:0]  cps_ff;

   // sequencer
   state_type  state_ff, state_in;
   logic [1:0] term_ff, term_in;
   logic       issued_ff, issued_in;

   // per-update datapath
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      dneg_ff, dneg_in;
   logic [SPD_W-1:0]          dmag_ff, dmag_in;
   logic [CHG_W-1:0]          chg_ff, chg_in;
   logic [MUL_AW-1:0]         gg_ff, gg_in;
   logic signed [TERM_SW-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in;
   logic [DUTY_W-1:0]         duty_ff, duty_in;
   logic [PWM_W-1:0]          pwm_ff, pwm_in;

   // persistent state
   logic [INT_W-1:0] integ_ff, integ_in;
   logic [SPD_W-1:0] last_ff, last_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]       rsp_duty_ff, rsp_duty_in;
   logic [PWM_W-1:0]        rsp_pwm_ff, rsp_pwm_in;
   logic signed [ERR_W-1:0] rsp_err_ff, rsp_err_in;

   // helpers
   logic                      accept;
   logic                      out_free;
   logic                      mul_phase;
   logic                      mul_start, mul_done;
   logic [MUL_AW-1:0]         mul_a;
   logic [MUL_BW-1:0]         mul_b;
   logic [PROD_W-1:0]         mul_prod;
   logic                      gs_done;
   logic [GN_W-1:0]           gn;
   logic [GAIN_W-1:0]         gain_sel;
   logic [SPD_W-1:0]          err_mag;
   logic signed [ERR_W-1:0]   diff;
   logic [TERM_W-1:0]         term_mag;
   logic                      term_neg;
   logic signed [TERM_SW-1:0] term_val;
   logic signed [SUM_W-1:0]   isum, dsum;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Register write port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= KP_RST;
         ki_ff    <= KI_RST;
         kd_ff    <= KD_RST;
         zone_ff  <= DEADZONE_RST;
         rate_ff  <= RATE_RST;
         floor_ff <= FLOOR_RST;
         ceil_ff  <= CEILING_RST;
         cps_ff   <= CPS_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_KP:       kp_ff    <= csr_data;
            REG_KI:       ki_ff    <= csr_data;
            REG_KD:       kd_ff    <= csr_data;
            REG_DEADZONE: zone_ff  <= csr_data;
            REG_RATE:     rate_ff  <= csr_data[RATE_W-1:0];
            REG_FLOOR:    floor_ff <= csr_data[DUTY_W-1:0];
            REG_CEILING:  ceil_ff  <= csr_data[DUTY_W-1:0];
            REG_CPS:      cps_ff   <= csr_data[CPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Shared units
   // ---------------------------------------------------------------------
   fpsc_gsched u_gsched (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .target (req_target_speed),
      .done   (gs_done),
      .gn     (gn)
   );

   fpsc_mul #(
      .AW (MUL_AW),
      .BW (MUL_BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCHED;
               term_in  = TERM_P;
            end
         end
         ST_SCHED: begin
            if (gs_done) state_in = ST_RATE;
         end
         ST_RATE: begin
            if (mul_done) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            if (mul_done) state_in = ST_MAG;
         end
         ST_MAG: begin
            if (mul_done) begin
               if (term_ff == TERM_D) begin
                  state_in = ST_INT;
               end else begin
                  state_in = ST_GAIN;
                  term_in  = term_ff + 1'b1;
               end
            end
         end
         ST_INT:  state_in = ST_DUTY;
         ST_DUTY: state_in = ST_PWM;
         ST_PWM: begin
            if (mul_done) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs and multiplier operand selection
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_phase = (state_ff inside {ST_RATE, ST_GAIN, ST_MAG, ST_PWM});
      mul_start = mul_phase && !issued_ff;
      issued_in = issued_ff;
      if (mul_start) begin
         issued_in = 1'b1;
      end else if (mul_done) begin
         issued_in = 1'b0;
      end

      case (term_ff)
         TERM_P:  gain_sel = kp_ff;
         TERM_I:  gain_sel = ki_ff;
         TERM_D:  gain_sel = kd_ff;
         default: gain_sel = '0;
      endcase

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RATE: begin
            mul_a = MUL_AW'(dmag_ff);
            mul_b = MUL_BW'(rate_ff);
         end
         ST_GAIN: begin
            mul_a = MUL_AW'(gn);
            mul_b = MUL_BW'(gain_sel);
         end
         ST_MAG: begin
            mul_a = gg_ff;
            mul_b = (term_ff == TERM_D) ? chg_ff : MUL_BW'(err_mag);
         end
         ST_PWM: begin
            mul_a = MUL_AW'(duty_ff);
            mul_b = MUL_BW'(cps_ff);
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      err_in   = err_ff;
      dneg_in  = dneg_ff;
      dmag_in  = dmag_ff;
      chg_in   = chg_ff;
      gg_in    = gg_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      d_in     = d_ff;
      duty_in  = duty_ff;
      pwm_in   = pwm_ff;
      integ_in = integ_ff;
      last_in  = last_ff;

      err_mag  = err_ff[ERR_W-1] ? SPD_W'(-err_ff) : SPD_W'(err_ff);
      diff     = signed'(ERR_W'(last_ff)) - signed'(ERR_W'(req_measured_speed));

      // drop the Q28 fraction, then restore the sign: truncates toward zero
      term_mag = mul_prod[PROD_W-1:Q_SHIFT];
      term_neg = (term_ff == TERM_D) ? dneg_ff : err_ff[ERR_W-1];
      term_val = term_neg ? -signed'(TERM_SW'(term_mag)) : signed'(TERM_SW'(term_mag));

      isum = signed'(SUM_W'(integ_ff)) + SUM_W'(i_ff);
      dsum = signed'(SUM_W'(integ_ff)) + SUM_W'(p_ff) + SUM_W'(d_ff);

      if (accept) begin
         err_in  = signed'(ERR_W'(req_target_speed))
                 - signed'(ERR_W'(req_measured_speed));
         dneg_in = diff[ERR_W-1];
         dmag_in = diff[ERR_W-1] ? SPD_W'(-diff) : SPD_W'(diff);
         last_in = req_measured_speed;
      end

      case (state_ff)
         ST_RATE: begin
            if (mul_done) chg_in = mul_prod[CHG_W-1:0];
         end
         ST_GAIN: begin
            if (mul_done) gg_in = mul_prod[MUL_AW-1:0];
         end
         ST_MAG: begin
            if (mul_done) begin
               case (term_ff)
                  TERM_P: p_in = term_val;
                  TERM_I: i_in = term_val;
                  TERM_D: begin
                     // dead zone: no derivative action on small changes
                     d_in = (chg_ff > CHG_W'(zone_ff)) ? term_val : '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_INT: begin
            integ_in = INT_W'(clamp_duty(isum, ceil_ff, floor_ff));
         end
         ST_DUTY: begin
            duty_in = clamp_duty(dsum, ceil_ff, floor_ff);
         end
         ST_PWM: begin
            if (mul_done) pwm_in = mul_prod[PWM_W-1:0];
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: load from HOLD when the slot is free
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_err_in   = rsp_err_ff;
      if (state_ff == ST_HOLD && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_duty_in  = duty_ff;
         rsp_pwm_in   = pwm_ff;
         rsp_err_in   = err_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      dneg_ff     <= dneg_in;
      dmag_ff     <= dmag_in;
      chg_ff      <= chg_in;
      gg_ff       <= gg_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      duty_ff     <= duty_in;
      pwm_ff      <= pwm_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_pwm_ff  <= rsp_pwm_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_P;
         issued_ff    <= 1'b0;
         integ_ff     <= IntReset;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         issued_ff    <= issued_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_duty            = rsp_duty_ff;
   assign rsp_pwm_high_cycles = rsp_pwm_ff;
   assign rsp_speed_error     = rsp_err_ff;

endmodule

`default_nettype wire

// ----- test/fpsc_checker.sv -----
// Scoreboard for the fan PID speed controller: watches the request, response and
// register ports, predicts each duty update and compares it with the block's result.
// Depends on fpsc_pkg for port widths and register indexes.
`default_nettype none

module fpsc_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic [fpsc_pkg::TGT_W-1:0]        req_target_speed,
   input  wire logic [fpsc_pkg::SPD_W-1:0]        req_measured_speed,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [fpsc_pkg::DUTY_W-1:0]       rsp_duty,
   input  wire logic [fpsc_pkg::PWM_W-1:0]        rsp_pwm_high_cycles,
   input  wire logic signed [fpsc_pkg::ERR_W-1:0] rsp_speed_error,
   input  wire logic                              csr_write,
   input  wire logic [fpsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fpsc_pkg::CSR_W-1:0]        csr_data,
   output int unsigned                            mismatch_count,
   output int unsigned                            pending_updates
);

   import fpsc_pkg::*;

   localparam bit [63:0] GAIN_SCHED_LOW = 64'd116654;   // 1.78 in Q16
   localparam bit [63:0] GAIN_SCHED_KNEE = 64'd800;
   localparam int        TERM_SHIFT = 28;
   localparam int        REPORT_LIMIT = 10;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [PWM_W-1:0]  pwm_high_cycles;
      logic [ERR_W-1:0]  speed_error;
   } duty_result_type;

   // Shadow registers and controller state
   logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
   logic [ZONE_W-1:0] deadzone_q;
   logic [RATE_W-1:0] rate_q;
   logic [DUTY_W-1:0] floor_q, ceiling_q;
   logic [CPS_W-1:0]  cps_q;
   longint            integral_q;
   logic [SPD_W-1:0]  last_speed_q;

   duty_result_type duty_expected_q[$];
   duty_result_type got, want;
   int unsigned     failures = 0;
   int unsigned     results_seen = 0;

   // |gain * gn * value| >> 28, sign of value restored: truncates toward zero
   function automatic longint gained_term(input bit [63:0] gain, input bit [63:0] gn,
                                          input longint value);
      bit [63:0] mag;
      bit [63:0] prod;
      mag = (value < 0) ? 64'(-value) : 64'(value);
      prod = (gain * gn * mag) >> TERM_SHIFT;
      return (value < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   // Ceiling is tested first; with crossed limits a value above the ceiling gets the ceiling, any other the floor
   function automatic longint clamp_to_limits(input longint v);
      if (v > longint'(ceiling_q)) return longint'(ceiling_q);
      if (v < longint'(floor_q)) return longint'(floor_q);
      return v;
   endfunction

   function automatic duty_result_type pid_update(input logic [TGT_W-1:0] tgt,
                                                  input logic [SPD_W-1:0] spd);
      longint          err, p_term, d_term, change, change_mag, duty, pwm_full;
      bit [63:0]       gn;
      duty_result_type r;
      err = longint'(tgt) - longint'(spd);
      if (64'(tgt) <= GAIN_SCHED_KNEE) begin
         gn = GAIN_SCHED_LOW;
      end else begin
         gn = (64'(tgt) * 64'd89 * 64'd65536) / 64'd40000;
      end
      p_term = gained_term(64'(kp_q), gn, err);
      integral_q = clamp_to_limits(integral_q + gained_term(64'(ki_q), gn, err));
      change = (longint'(last_speed_q) - longint'(spd)) * longint'(rate_q);
      change_mag = (change < 0) ? -change : change;
      d_term = (change_mag > longint'(deadzone_q)) ? gained_term(64'(kd_q), gn, change) : 0;
      duty = clamp_to_limits(integral_q + p_term + d_term);
      last_speed_q = spd;
      pwm_full = duty * longint'(cps_q);
      r.duty = duty[DUTY_W-1:0];
      r.pwm_high_cycles = pwm_full[PWM_W-1:0];
      r.speed_error = err[ERR_W-1:0];
      return r;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic check_field(input string field, input longint exp_v, input longint got_v);
      if (exp_v != got_v) begin
         note_failure($sformatf("update %0d: %s expected %0d, got %0d",
                                results_seen, field, exp_v, got_v));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kp_q = 16'd20480;
         ki_q = 16'd1638;
         kd_q = 16'd819;
         deadzone_q = 16'd100;
         rate_q = 8'd10;
         floor_q = 14'd100;
         ceiling_q = 14'd10000;
         cps_q = 8'd16;
         integral_q = 5000;
         last_speed_q = '0;
         duty_expected_q.delete();
      end else begin
         // compare against the queue as it stood before this edge
         if (rsp_valid && !rsp_stall) begin
            got.duty = rsp_duty;
            got.pwm_high_cycles = rsp_pwm_high_cycles;
            got.speed_error = rsp_speed_error;
            if (duty_expected_q.size() == 0) begin
               note_failure($sformatf("unexpected result: duty %0d, pwm %0d, error %0d",
                                      rsp_duty, rsp_pwm_high_cycles, rsp_speed_error));
            end else begin
               want = duty_expected_q.pop_front();
               check_field("duty", longint'(want.duty), longint'(got.duty));
               check_field("pwm_high_cycles", longint'(want.pwm_high_cycles),
                           longint'(got.pwm_high_cycles));
               check_field("speed_error", longint'(signed'(want.speed_error)),
                           longint'(signed'(got.speed_error)));
            end
            results_seen++;
         end
         if (csr_write) begin
            case (csr_index)
               REG_KP:       kp_q = csr_data;
               REG_KI:       ki_q = csr_data;
               REG_KD:       kd_q = csr_data;
               REG_DEADZONE: deadzone_q = csr_data;
               REG_RATE:     rate_q = csr_data[RATE_W-1:0];
               REG_FLOOR:    floor_q = csr_data[DUTY_W-1:0];
               REG_CEILING:  ceiling_q = csr_data[DUTY_W-1:0];
               REG_CPS:      cps_q = csr_data[CPS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            duty_expected_q.push_back(pid_update(req_target_speed, req_measured_speed));
         end
      end
      pending_updates <= duty_expected_q.size();
      mismatch_count <= failures;
   end

endmodule

`default_nettype wire

// ----- test/tb_fan_pid_speed_controller_unit.sv -----
// Top of the fan PID speed controller testbench: clock, reset, register setup,
// speed update stimulus with random idling, and the verdict.
// Depends on fpsc_pkg, fan_pid_speed_controller_unit and fpsc_checker.
`default_nettype none

module tb_fan_pid_speed_controller_unit;

   import fpsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;   // idle cycles before giving up
   localparam int HOLD_OFF_CYCLES = 1500;   // one long receiver hold-off
   localparam int HOLD_OFF_AFTER = 100;     // results seen before the hold-off
   localparam int DIRECTED_COUNT = 21;

   logic clock = 1'b0;
   logic reset;

   logic                     req_valid;
   logic                     req_stall;
   logic [TGT_W-1:0]         req_target_speed;
   logic [SPD_W-1:0]         req_measured_speed;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [DUTY_W-1:0]        rsp_duty;
   logic [PWM_W-1:0]         rsp_pwm_high_cycles;
   logic signed [ERR_W-1:0]  rsp_speed_error;
   logic                     csr_write;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_W-1:0]         csr_data;

   int unsigned mismatch_count;
   int unsigned pending_updates;
   int unsigned idle_cycles = 0;
   int unsigned duty_transfers = 0;
   bit          calm_phase = 1'b0;   // no gaps and no stalls while set

   // Tracking state for well-formed speed sequences
   int          track_target = 1000;
   int          track_left = 0;

   // Directed updates: knee of the gain schedule, field extremes, integral
   // pushed to both limits, and speed steps right at and just past the dead zone
   int dir_target[DIRECTED_COUNT] = '{500, 2500, 800, 801, 2500, 2500, 2500,
                                      500, 500, 500, 1000, 1000, 1000, 1000, 1000,
                                      1024, 2047, 1365, 682, 2500, 500};
   int dir_speed[DIRECTED_COUNT]  = '{0, 16383, 800, 0, 0, 0, 0,
                                      16383, 16383, 16383, 1000, 1010, 1021, 1011, 1000,
                                      2048, 4095, 8191, 10922, 2500, 500};

   always #5 clock = ~clock;

   fan_pid_speed_controller_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_speed    (req_target_speed),
      .req_measured_speed  (req_measured_speed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty            (rsp_duty),
      .rsp_pwm_high_cycles (rsp_pwm_high_cycles),
      .rsp_speed_error     (rsp_speed_error),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   fpsc_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_speed    (req_target_speed),
      .req_measured_speed  (req_measured_speed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty            (rsp_duty),
      .rsp_pwm_high_cycles (rsp_pwm_high_cycles),
      .rsp_speed_error     (rsp_speed_error),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatch_count      (mismatch_count),
      .pending_updates     (pending_updates)
   );

   // Watchdog: restart on any transfer or register write, give up after a
   // long stretch where nothing moves
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) duty_transfers <= duty_transfers + 1;
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short sender gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one update and hold it until the block takes it
   task automatic send_update(input int tgt, input int spd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_target_speed <= tgt[TGT_W-1:0];
      req_measured_speed <= spd[SPD_W-1:0];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic drain_updates();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_updates != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_W-1:0];
      @(posedge clock);
   endtask

   // Write all eight registers back to back; call only with the block idle
   task automatic set_regs(input int kp, input int ki, input int kd, input int zone,
                           input int rate, input int floor_v, input int ceil_v,
                           input int cps);
      write_reg(REG_KP, kp);
      write_reg(REG_KI, ki);
      write_reg(REG_KD, kd);
      write_reg(REG_DEADZONE, zone);
      write_reg(REG_RATE, rate);
      write_reg(REG_FLOOR, floor_v);
      write_reg(REG_CEILING, ceil_v);
      write_reg(REG_CPS, cps);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a fan settling around a target that changes now and then; the
   // rest is noise over the whole speed range
   task automatic run_phase(input int count);
      int tgt, spd, r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (track_left == 0) begin
            track_target = $urandom_range(500, 2500);
            track_left = $urandom_range(4, 20);
         end
         track_left--;
         if (r < 12) begin
            tgt = $urandom_range(500, 2500);
            spd = $urandom_range(0, 16383);
         end else begin
            tgt = track_target;
            if (r < 22) spd = tgt + $urandom_range(0, 6000) - 3000;
            else spd = tgt + $urandom_range(0, 600) - 300;
            if (spd < 0) spd = 0;
            if (spd > 16383) spd = 16383;
         end
         send_update(tgt, spd);
      end
      drain_updates();
   endtask

   // Receiver: random stalls, one long hold-off so the block backs up into
   // the request side, none at all during the calm phase
   initial begin
      int  r;
      int  run;
      bit  held;
      held = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (!held && duty_transfers >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            run = HOLD_OFF_CYCLES;
         end else if (calm_phase || r < 55) begin
            rsp_stall <= 1'b0;
            run = $urandom_range(1, 30);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            run = $urandom_range(1, 4);
         end else begin
            rsp_stall <= 1'b1;
            run = $urandom_range(20, 120);
         end
         repeat (run) @(posedge clock);
      end
   end

   initial begin
      int floor_v;
      req_valid = 1'b0;
      req_target_speed = '0;
      req_measured_speed = '0;
      csr_write = 1'b0;
      csr_index = REG_KP;
      csr_data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed updates on reset settings; the first one sees a zero last speed
      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         send_update(dir_target[n], dir_speed[n]);
      end
      drain_updates();

      // Gains, update rate and clocks per step at maximum, no dead zone
      set_regs(65535, 65535, 65535, 0, 255, 0, 10000, 255);
      run_phase(55);
      // Everything at zero but the dead zone, which is at maximum: zero update rate and a zero ceiling
      set_regs(0, 0, 0, 65535, 0, 0, 0, 0);
      run_phase(40);
      // Floor above ceiling
      set_regs(20480, 4096, 819, 100, 10, 9000, 2000, 16);
      run_phase(50);
      // Limits beyond full scale, slowest nonzero update rate
      set_regs(8192, 2048, 4096, 50, 1, 16383, 16383, 255);
      run_phase(40);
      // Back to reset values with no idling on either side
      calm_phase = 1'b1;
      set_regs(20480, 1638, 819, 100, 10, 100, 10000, 16);
      run_phase(60);
      calm_phase = 1'b0;
      // Random settings
      for (int p = 0; p < 5; p++) begin
         floor_v = $urandom_range(0, 3000);
         set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 2000),
                  $urandom_range(1, 255), floor_v, $urandom_range(floor_v, 10000),
                  $urandom_range(0, 255));
         run_phase(60);
      end

      // Let any stray result show up before the verdict
      repeat (250) @(posedge clock);
      if (mismatch_count == 0 && pending_updates == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/fpsc_pkg.sv
rtl/fpsc_mul.sv
rtl/fpsc_gsched.sv
rtl/fan_pid_speed_controller_unit.sv
test/fpsc_checker.sv
test/tb_fan_pid_speed_controller_unit.sv
